// ===== rtl/osrb_pkg.sv =====
// Shared constants and codes for the ordered slot reorder buffer.
// No dependencies; used by ordered_slot_reorder_buffer_unit.
package osrb_pkg;

    // Slot pool size and derived widths
    localparam int SLOTS    = 16;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = IDX_W + 1;
    localparam int SLOT_W   = 4;
    localparam int SEQ_W    = 32;

    // Residue of 2^32 modulo SLOTS, used when a sequence window crosses the wrap point
    localparam longint unsigned WRAP_ADJ_L = (64'd1 << SEQ_W) % SLOTS;
    localparam logic [CNT_W-1:0] WRAP_ADJ  = CNT_W'(WRAP_ADJ_L);

    // Request kinds
    typedef enum logic [1:0] {
        KIND_TAKE_FREE = 2'd0,
        KIND_COMPLETE  = 2'd1,
        KIND_TAKE_NEXT = 2'd2,
        KIND_RELEASE   = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_OUT_WIN   = 2'd2,
        ST_FREE_FULL = 2'd3
    } t_status;

endpackage

// ===== rtl/ordered_slot_reorder_buffer_unit.sv =====
// Ordered slot reorder buffer: free-list FIFO plus in-order completion window.
// Depends on osrb_pkg for sizes and request/status codes.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------------------
//   in      | sink      | i_in_valid / o_in_ready    | i_kind, i_slot, i_seq_num
//   out     | source    | o_out_valid / i_out_ready  | o_status, o_slot_out, o_seq_out
//
// A request is captured in an input register, evaluated against the slot state while
// it sits there, and its result is loaded into the output register.
// One request per cycle is sustained while the output side is not stalled.
// The input register refills while the output register is drained, so a stall on
// the output side stops the pipeline only when both registers are full.
// Reset (i_rst_n low, synchronous) fills the free list with every slot in order,
// clears all completion flags and the expected sequence number; no clearing pass.
module ordered_slot_reorder_buffer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_kind,
    input  logic [osrb_pkg::SLOT_W-1:0] i_slot,
    input  logic [osrb_pkg::SEQ_W-1:0]  i_seq_num,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [osrb_pkg::SLOT_W-1:0] o_slot_out,
    output logic [osrb_pkg::SEQ_W-1:0]  o_seq_out
);

    localparam int IDX_W  = osrb_pkg::IDX_W;
    localparam int CNT_W  = osrb_pkg::CNT_W;
    localparam int SLOT_W = osrb_pkg::SLOT_W;
    localparam int SEQ_W  = osrb_pkg::SEQ_W;
    localparam int SLOTS  = osrb_pkg::SLOTS;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    // Input register
    logic                    r_in_vld;
    osrb_pkg::t_kind         r_kind;
    logic [SLOT_W-1:0]       r_slot;
    logic [SEQ_W-1:0]        r_seq;

    // Result register
    logic                    r_out_vld;
    osrb_pkg::t_status       r_status;
    logic [SLOT_W-1:0]       r_slot_out;
    logic [SEQ_W-1:0]        r_seq_out;

    // Slot state
    logic [SLOT_W-1:0]       r_free_fifo [SLOTS];
    logic [IDX_W-1:0]        r_free_head;
    logic [CNT_W-1:0]        r_free_count;
    logic [SLOT_W-1:0]       r_done_slot [SLOTS];
    logic [SLOTS-1:0]        r_done_valid;
    logic [SEQ_W-1:0]        r_next_seq;
    logic [IDX_W-1:0]        r_next_idx;

    // Next-value and control signals
    logic                    advance;
    osrb_pkg::t_status       n_status;
    logic [SLOT_W-1:0]       n_slot_out;
    logic [SEQ_W-1:0]        n_seq_out;
    logic                    do_take;
    logic                    do_complete;
    logic                    do_next;
    logic                    do_release;
    logic [IDX_W-1:0]        n_free_head;
    logic [IDX_W-1:0]        n_next_idx;
    logic [SEQ_W-1:0]        seq_dist;
    logic                    in_window;
    logic [CNT_W-1:0]        idx_sum;
    logic [CNT_W-1:0]        idx_mod;
    logic [CNT_W-1:0]        idx_fix;
    logic [IDX_W-1:0]        done_idx;
    logic [CNT_W-1:0]        tail_sum;
    logic [IDX_W-1:0]        tail_idx;

    // Evaluate one request per cycle when the result register can take it
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    // Completion index: next_idx plus distance, wrapped, corrected for 2^32 crossing
    assign seq_dist  = r_seq - r_next_seq;
    assign in_window = seq_dist < SEQ_W'(SLOTS);
    assign idx_sum   = {1'b0, r_next_idx} + {1'b0, seq_dist[IDX_W-1:0]};
    assign idx_mod   = (idx_sum >= SLOTS_C) ? (idx_sum - SLOTS_C) : idx_sum;

    always_comb begin
        if (r_seq < r_next_seq) begin
            idx_fix = (idx_mod >= osrb_pkg::WRAP_ADJ) ? (idx_mod - osrb_pkg::WRAP_ADJ)
                                                      : (idx_mod + SLOTS_C - osrb_pkg::WRAP_ADJ);
        end else begin
            idx_fix = idx_mod;
        end
    end
    assign done_idx = idx_fix[IDX_W-1:0];

    // Free-list tail and pointer advance
    assign tail_sum    = {1'b0, r_free_head} + r_free_count;
    assign tail_idx    = (tail_sum >= SLOTS_C) ? IDX_W'(tail_sum - SLOTS_C)
                                               : tail_sum[IDX_W-1:0];
    assign n_free_head = (r_free_head == IDX_W'(SLOTS - 1)) ? '0 : r_free_head + 1'b1;

    // Expected-index advance, restarting at zero at the end of the slot pool or when the sequence number wraps
    assign n_next_idx  = (r_next_seq == '1) ? '0 :
                         (r_next_idx == IDX_W'(SLOTS - 1)) ? '0 : r_next_idx + 1'b1;

    // Decode request and form the result
    always_comb begin
        n_status    = osrb_pkg::ST_OK;
        n_slot_out  = '0;
        n_seq_out   = '0;
        do_take     = 1'b0;
        do_complete = 1'b0;
        do_next     = 1'b0;
        do_release  = 1'b0;
        unique case (r_kind)
            osrb_pkg::KIND_TAKE_FREE: begin
                if (r_free_count == '0) begin
                    n_status = osrb_pkg::ST_NOT_READY;
                end else begin
                    n_slot_out = r_free_fifo[r_free_head];
                    do_take    = 1'b1;
                end
            end
            osrb_pkg::KIND_COMPLETE: begin
                if (!in_window) begin
                    n_status = osrb_pkg::ST_OUT_WIN;
                end else begin
                    do_complete = 1'b1;
                end
            end
            osrb_pkg::KIND_TAKE_NEXT: begin
                if (!r_done_valid[r_next_idx]) begin
                    n_status = osrb_pkg::ST_NOT_READY;
                end else begin
                    n_slot_out = r_done_slot[r_next_idx];
                    n_seq_out  = r_next_seq;
                    do_next    = 1'b1;
                end
            end
            osrb_pkg::KIND_RELEASE: begin
                if (r_free_count >= SLOTS_C) begin
                    n_status = osrb_pkg::ST_FREE_FULL;
                end else begin
                    do_release = 1'b1;
                end
            end
            default: begin
                n_status = osrb_pkg::ST_OK;
            end
        endcase
    end

    // Capture input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_kind <= osrb_pkg::t_kind'(i_kind);
            r_slot <= i_slot;
            r_seq  <= i_seq_num;
        end
    end

    // Hold or load the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (advance) begin
            r_status   <= n_status;
            r_slot_out <= n_slot_out;
            r_seq_out  <= n_seq_out;
        end
    end

    // Free list: pointer, count and entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head  <= '0;
            r_free_count <= SLOTS_C;
            for (int i = 0; i < SLOTS; i++) begin
                r_free_fifo[i] <= SLOT_W'(i);
            end
        end else if (advance) begin
            if (do_take) begin
                r_free_head  <= n_free_head;
                r_free_count <= r_free_count - 1'b1;
            end
            if (do_release) begin
                r_free_fifo[tail_idx] <= r_slot;
                r_free_count          <= r_free_count + 1'b1;
            end
        end
    end

    // Completion window: flags, expected number and its index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done_valid <= '0;
            r_next_seq   <= '0;
            r_next_idx   <= '0;
        end else if (advance) begin
            if (do_complete) begin
                r_done_valid[done_idx] <= 1'b1;
            end
            if (do_next) begin
                r_done_valid[r_next_idx] <= 1'b0;
                r_next_seq               <= r_next_seq + 1'b1;
                r_next_idx               <= n_next_idx;
            end
        end
    end

    // Completed slot tags, no reset
    always_ff @(posedge i_clk) begin
        if (advance && do_complete) begin
            r_done_slot[done_idx] <= r_slot;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_status    = r_status;
    assign o_slot_out  = r_slot_out;
    assign o_seq_out   = r_seq_out;

    // Free count stays within the pool
    a_free_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= SLOTS_C)
        else $error("free count exceeds pool size");

    // A granted slot shrinks the free list by one
    a_take_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && do_take |=> r_free_count == $past(r_free_count) - 1'b1)
        else $error("free count did not drop after grant");

    // An in-order take-next advances the expected sequence number
    a_next_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && do_next |=> r_next_seq == $past(r_next_seq) + 1'b1)
        else $error("expected sequence did not advance");

    // Results other than ok carry zero payload
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_status != osrb_pkg::ST_OK |-> r_slot_out == '0 && r_seq_out == '0)
        else $error("non-ok result carries payload");

endmodule
